// File: hdl/taa_pkg.sv
// Shared constants, types and the step-width table for the thermistor converter.
`timescale 1ns / 1ps

package taa_pkg;

  // Averaging window and field widths.
  localparam int SAMPLES    = 8;
  localparam int ADC_W      = 10;
  localparam int TEMP_W     = 11;
  localparam int STATUS_W   = 2;
  localparam int POLL_W     = 8;
  localparam int USED_W     = $clog2(SAMPLES + 1);
  localparam int HIST_IDX_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  localparam int SUM_W      = ADC_W + $clog2(SAMPLES);

  localparam logic [POLL_W-1:0] POLL_LIMIT = POLL_W'(255);

  // Conversion table geometry.
  localparam int TABLE_STEPS = 128;
  localparam int STEP_W      = $clog2(TABLE_STEPS);
  localparam int WIDTH_W     = 4;
  localparam int LOWER_W     = 11;
  localparam int CALC_W      = 12;

  localparam logic [ADC_W-1:0] TABLE_START_COUNT = ADC_W'(65);
  localparam int START_KELVIN  = -27 + 273;
  localparam int KELVIN_TENTHS = 273 * 10;
  localparam int TENTHS_OFFSET = KELVIN_TENTHS - START_KELVIN * 10;

  localparam logic signed [TEMP_W-1:0] COLD_TENTHS = TEMP_W'((START_KELVIN - 273) * 10);
  localparam logic signed [TEMP_W-1:0] HOT_TENTHS  =
    TEMP_W'((START_KELVIN + TABLE_STEPS - 1 - 273) * 10);

  // Shared divider geometry: averages and interpolation both go through it.
  localparam int DEN_W = (USED_W > WIDTH_W) ? USED_W : WIDTH_W;
  localparam int NUM_W = SUM_W;

  typedef enum logic [STATUS_W-1:0] {
    RANGE_OK   = 2'd0,
    RANGE_COLD = 2'd1,
    RANGE_HOT  = 2'd2
  } range_status_t;

  typedef struct packed {
    logic [SUM_W-1:0]  total;
    logic [USED_W-1:0] used;
  } avg_job_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quot;
  } div_rsp_t;

  // Two step widths per byte, high nibble first; one step is one degree.
  localparam logic [7:0] STEP_WIDTHS [TABLE_STEPS/2] = '{
    8'h44, 8'h45, 8'h45, 8'h55, 8'h66, 8'h66, 8'h67, 8'h67, 8'h87, 8'h88, 8'h88, 8'h98,
    8'h9a, 8'h99, 8'haa, 8'haa, 8'hba, 8'hba, 8'hbb, 8'hbb, 8'hbb, 8'hbc, 8'hbb, 8'hbb,
    8'hbc, 8'hbb, 8'hab, 8'hbb, 8'haa, 8'hba, 8'haa, 8'ha9, 8'ha9, 8'h99, 8'h98, 8'h98,
    8'h88, 8'h88, 8'h77, 8'h77, 8'h77, 8'h67, 8'h66, 8'h65, 8'h65, 8'h56, 8'h54, 8'h55,
    8'h44, 8'h54, 8'h44, 8'h34, 8'h43, 8'h34, 8'h33, 8'h33, 8'h32, 8'h33, 8'h23, 8'h22,
    8'h32, 8'h22, 8'h22, 8'h20
  };

  function automatic logic [WIDTH_W-1:0] step_width(input logic [STEP_W-1:0] step);
    logic [7:0] packed_w;
    packed_w = STEP_WIDTHS[step[STEP_W-1:1]];
    return step[0] ? packed_w[3:0] : packed_w[7:4];
  endfunction

endpackage

// File: hdl/taa_if.sv
// Valid/ready channel interfaces for converter readings and temperature results.
`timescale 1ns / 1ps

interface taa_sample_if;
  import taa_pkg::*;
  logic             valid;
  logic             ready;
  logic [ADC_W-1:0] adc_sample;
  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

interface taa_result_if;
  import taa_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temp_tenths_c;
  logic [STATUS_W-1:0]      range_status;
  modport source (output valid, output temp_tenths_c, output range_status, input ready);
  modport sink   (input valid, input temp_tenths_c, input range_status, output ready);
endinterface

// File: hdl/taa_divider.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module taa_divider (
  input  logic              clk,
  input  logic              rst,
  input  taa_pkg::div_req_t req,
  output taa_pkg::div_rsp_t rsp
);
  import taa_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] work;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [DEN_W:0]   rem_shift;
  logic [DEN_W:0]   rem_sub;
  logic             fits;

  always_comb begin
    rem_shift = {rem, work[NUM_W-1]};
    fits      = rem_shift >= {1'b0, den};
    rem_sub   = rem_shift - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
        work <= req.num;
        rem  <= '0;
        den  <= req.den;
      end else if (busy) begin
        // shift the next dividend bit in, keep the quotient bit
        work <= {work[NUM_W-2:0], fits};
        rem  <= fits ? rem_sub[DEN_W-1:0] : rem_shift[DEN_W-1:0];
        cnt  <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = work;

endmodule

// File: hdl/taa_front.sv
// Front end: takes readings, keeps the history and poll count, sums the window.
`timescale 1ns / 1ps

module taa_front (
  input  logic              clk,
  input  logic              rst,
  taa_sample_if.sink        sample_ch,
  output taa_pkg::avg_job_t job,
  output logic              job_valid,
  input  logic              job_ready
);
  import taa_pkg::*;

  typedef enum logic [1:0] {F_IDLE, F_SUM, F_PUSH} front_state_t;

  front_state_t          state;
  logic [ADC_W-1:0]      hist [SAMPLES];
  logic [POLL_W-1:0]     poll_count;
  logic [POLL_W-1:0]     poll_count_next;
  logic [USED_W-1:0]     used;
  logic [USED_W-1:0]     used_next;
  logic [USED_W-1:0]     k;
  logic [SUM_W-1:0]      total;
  logic [HIST_IDX_W-1:0] hist_idx;

  always_comb begin
    poll_count_next = (poll_count < POLL_LIMIT) ? poll_count + POLL_W'(1) : poll_count;
    used_next = (poll_count_next < POLL_W'(SAMPLES)) ? USED_W'(poll_count_next)
                                                      : USED_W'(SAMPLES);
    // walk back from the newest entry
    hist_idx = HIST_IDX_W'(SAMPLES - 1) - k[HIST_IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= F_IDLE;
      poll_count <= '0;
      for (int i = 0; i < SAMPLES; i++) begin
        hist[i] <= '0;
      end
    end else begin
      unique case (state)
        F_IDLE: begin
          if (sample_ch.valid) begin
            for (int i = 0; i < SAMPLES - 1; i++) begin
              hist[i] <= hist[i+1];
            end
            hist[SAMPLES-1] <= sample_ch.adc_sample;
            poll_count      <= poll_count_next;
            used            <= used_next;
            k               <= '0;
            total           <= '0;
            state           <= F_SUM;
          end
        end
        F_SUM: begin
          total <= total + SUM_W'(hist[hist_idx]);
          if (k == used - USED_W'(1)) begin
            state <= F_PUSH;
          end else begin
            k <= k + USED_W'(1);
          end
        end
        F_PUSH: begin
          if (job_ready) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  assign sample_ch.ready = (state == F_IDLE);
  assign job_valid       = (state == F_PUSH);
  assign job.total       = total;
  assign job.used        = used;

endmodule

// File: hdl/taa_fifo.sv
// Two-entry queue of window sums between front and back.
`timescale 1ns / 1ps

module taa_fifo (
  input  logic              clk,
  input  logic              rst,
  input  taa_pkg::avg_job_t wr_data,
  input  logic              wr_valid,
  output logic              wr_ready,
  output taa_pkg::avg_job_t rd_data,
  output logic              rd_valid,
  input  logic              rd_ready
);
  import taa_pkg::*;

  avg_job_t   mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  logic       pop;

  assign wr_ready = (fill != 2'd2);
  assign rd_valid = (fill != 2'd0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        mem[wr_ptr] <= wr_data;
        wr_ptr      <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// File: hdl/taa_back.sv
// Back end: divides the window sum, walks the table, interpolates, holds the result.
`timescale 1ns / 1ps

module taa_back (
  input  logic              clk,
  input  logic              rst,
  input  taa_pkg::avg_job_t job,
  input  logic              job_valid,
  output logic              job_ready,
  output taa_pkg::div_req_t div_req,
  input  taa_pkg::div_rsp_t div_rsp,
  taa_result_if.source      result_ch
);
  import taa_pkg::*;

  typedef enum logic [2:0] {B_IDLE, B_AVG, B_WALK, B_PART, B_OUT} back_state_t;

  back_state_t              state;
  logic [ADC_W-1:0]         avg;
  logic [LOWER_W-1:0]       lower;
  logic [STEP_W-1:0]        step;
  logic signed [TEMP_W-1:0] temp;
  range_status_t            status;

  logic [WIDTH_W-1:0] width;
  logic [LOWER_W-1:0] upper;
  logic [LOWER_W-1:0] diff;
  logic               hit;
  logic [NUM_W-1:0]   part_num;
  logic [ADC_W-1:0]   avg_q;
  logic [CALC_W-1:0]  part_tenths;

  always_comb begin
    width    = step_width(step);
    upper    = lower + LOWER_W'(width);
    hit      = (LOWER_W'(avg) >= lower) && (LOWER_W'(avg) < upper);
    diff     = LOWER_W'(avg) - lower;
    part_num = NUM_W'(NUM_W'(diff[WIDTH_W-1:0]) * NUM_W'(10));
    avg_q    = div_rsp.quot[ADC_W-1:0];
    part_tenths = CALC_W'(step) * CALC_W'(10) + CALC_W'(div_rsp.quot[WIDTH_W-1:0])
                  - CALC_W'(TENTHS_OFFSET);

    div_req.start = 1'b0;
    div_req.num   = '0;
    div_req.den   = '0;
    if (state == B_IDLE && job_valid) begin
      div_req.start = 1'b1;
      div_req.num   = NUM_W'(job.total);
      div_req.den   = DEN_W'(job.used);
    end else if (state == B_WALK && hit) begin
      // a zero-width step never hits, so the divisor is never zero
      div_req.start = 1'b1;
      div_req.num   = part_num;
      div_req.den   = DEN_W'(width);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      unique case (state)
        B_IDLE: begin
          if (job_valid) begin
            state <= B_AVG;
          end
        end
        B_AVG: begin
          if (div_rsp.done) begin
            avg <= avg_q;
            if (avg_q < TABLE_START_COUNT) begin
              temp   <= COLD_TENTHS;
              status <= RANGE_COLD;
              state  <= B_OUT;
            end else begin
              lower <= LOWER_W'(TABLE_START_COUNT);
              step  <= '0;
              state <= B_WALK;
            end
          end
        end
        B_WALK: begin
          if (hit) begin
            state <= B_PART;
          end else begin
            lower <= upper;
            if (step == STEP_W'(TABLE_STEPS - 1)) begin
              temp   <= HOT_TENTHS;
              status <= RANGE_HOT;
              state  <= B_OUT;
            end else begin
              step <= step + STEP_W'(1);
            end
          end
        end
        B_PART: begin
          if (div_rsp.done) begin
            temp   <= part_tenths[TEMP_W-1:0];
            status <= RANGE_OK;
            state  <= B_OUT;
          end
        end
        B_OUT: begin
          if (result_ch.ready) begin
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  assign job_ready              = (state == B_IDLE);
  assign result_ch.valid        = (state == B_OUT);
  assign result_ch.temp_tenths_c = temp;
  assign result_ch.range_status = status;

endmodule

// File: hdl/thermistor_average_to_temperature.sv
// Top level: thermistor reading averager and temperature converter.
`timescale 1ns / 1ps

// Path: the front takes a reading and sums the N newest readings (N up to 8), the queue
//   holds the sum, then the back end divides for the average, walks up to 128 table
//   steps, clamps cold or hot or divides again to interpolate, and holds the result beat.
// Throughput: one beat per back-end pass; the table walk, one step a cycle, sets it.
// Reset (rst, synchronous): clears history, poll count, queue and all state machines.
module thermistor_average_to_temperature (
  input  logic         clk,
  input  logic         rst,
  taa_sample_if.sink   sample_ch,
  taa_result_if.source result_ch
);
  import taa_pkg::*;

  // Front to queue: window sum and the number of readings it covers.
  avg_job_t front_job;
  logic     front_valid;
  logic     front_ready;

  // Queue to back end.
  avg_job_t back_job;
  logic     back_valid;
  logic     back_ready;

  // Shared divider: the back end starts it for the average and for interpolation.
  div_req_t div_req;
  div_rsp_t div_rsp;

  // Shift the reading in, advance the poll count, sum the newest readings.
  taa_front u_front (
    .clk       (clk),
    .rst       (rst),
    .sample_ch (sample_ch),
    .job       (front_job),
    .job_valid (front_valid),
    .job_ready (front_ready)
  );

  // Hold up to two sums so the front keeps taking beats while the back works.
  taa_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_data  (front_job),
    .wr_valid (front_valid),
    .wr_ready (front_ready),
    .rd_data  (back_job),
    .rd_valid (back_valid),
    .rd_ready (back_ready)
  );

  taa_divider u_divider (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Average, walk the step table, clamp cold or hot, interpolate in tenths.
  taa_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (back_job),
    .job_valid (back_valid),
    .job_ready (back_ready),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .result_ch (result_ch)
  );

endmodule

// File: dv/testbench.sv
// Self-checking testbench for the thermistor reading averager and temperature converter.
`timescale 1ns / 1ps

module testbench;
  import taa_pkg::ADC_W;
  import taa_pkg::TEMP_W;
  import taa_pkg::range_status_t;
  import taa_pkg::RANGE_OK;
  import taa_pkg::RANGE_COLD;
  import taa_pkg::RANGE_HOT;

  // Averaging window and conversion-table geometry, kept apart from the RTL copy.
  localparam int          WINDOW_DEPTH = 8;
  localparam int          POLL_CEILING = 255;
  localparam int unsigned TABLE_BASE   = 65;   // count that stands for -27 C
  localparam int          BASE_DEG_C   = -27;
  localparam int          HOT_DEG_C    = BASE_DEG_C + 127;
  localparam int          DEGREE_STEPS = 128;
  localparam int          IDLE_PCT     = 17;
  localparam int          RANDOM_TOTAL = 550;
  localparam int          DRAIN_CYCLES = 200;  // longer than the worst back-end pass

  // Counts per degree, two steps per byte, high nibble first.
  localparam logic [7:0] DEGREE_SPANS [DEGREE_STEPS/2] = '{
    8'h44, 8'h45, 8'h45, 8'h55, 8'h66, 8'h66, 8'h67, 8'h67, 8'h87, 8'h88, 8'h88, 8'h98,
    8'h9a, 8'h99, 8'haa, 8'haa, 8'hba, 8'hba, 8'hbb, 8'hbb, 8'hbb, 8'hbc, 8'hbb, 8'hbb,
    8'hbc, 8'hbb, 8'hab, 8'hbb, 8'haa, 8'hba, 8'haa, 8'ha9, 8'ha9, 8'h99, 8'h98, 8'h98,
    8'h88, 8'h88, 8'h77, 8'h77, 8'h77, 8'h67, 8'h66, 8'h65, 8'h65, 8'h56, 8'h54, 8'h55,
    8'h44, 8'h54, 8'h44, 8'h34, 8'h43, 8'h34, 8'h33, 8'h33, 8'h32, 8'h33, 8'h23, 8'h22,
    8'h32, 8'h22, 8'h22, 8'h20
  };

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp;
    range_status_t            status;
  } temp_reading_t;

  // One row of stimulus; typed rows carry a hand-written answer.
  typedef struct {
    logic [ADC_W-1:0] adc;
    bit               typed;
    temp_reading_t    want;
  } adc_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  taa_sample_if sample_ch ();
  taa_result_if result_ch ();

  thermistor_average_to_temperature u_dut (
    .clk       (clk),
    .rst       (rst),
    .sample_ch (sample_ch),
    .result_ch (result_ch)
  );

  always #10 clk = ~clk;

  // Predictor state: the reading window (last entry newest) and the poll count.
  logic [ADC_W-1:0] window_hist [WINDOW_DEPTH];
  int               poll_total;

  adc_row_t      adc_rows [$];
  temp_reading_t pending_temps [$];
  temp_reading_t head_temp;
  int            fed_beats;
  int            error_count;
  logic          calm_window;

  // Hold both sides free of idling over a long middle stretch of the run.
  assign calm_window = (fed_beats >= 250) && (fed_beats < 350);

  // Map an averaged count onto tenths of a degree by walking the step table.
  function automatic temp_reading_t tenths_for_count(input int unsigned avg);
    temp_reading_t r;
    int unsigned   lower;
    int unsigned   span;
    logic [7:0]    packed_pair;
    r.status = RANGE_COLD;
    r.temp   = TEMP_W'(BASE_DEG_C * 10);
    if (avg < TABLE_BASE) begin
      return r;
    end
    lower = TABLE_BASE;
    for (int s = 0; s < DEGREE_STEPS; s++) begin
      packed_pair = DEGREE_SPANS[s / 2];
      span = (s % 2) ? packed_pair[3:0] : packed_pair[7:4];
      // A zero-width step can never match, so no divide by zero here.
      if (avg >= lower && avg < lower + span) begin
        r.status = RANGE_OK;
        r.temp   = TEMP_W'((BASE_DEG_C + s) * 10 + int'(((avg - lower) * 10) / span));
        return r;
      end
      lower += span;
    end
    r.status = RANGE_HOT;
    r.temp   = TEMP_W'(HOT_DEG_C * 10);
    return r;
  endfunction

  // Shift one reading into the window, bump the poll count and predict the beat.
  function automatic temp_reading_t absorb_reading(input logic [ADC_W-1:0] adc);
    int unsigned used;
    int unsigned total;
    total = 0;
    for (int k = 0; k < WINDOW_DEPTH - 1; k++) begin
      window_hist[k] = window_hist[k+1];
    end
    window_hist[WINDOW_DEPTH-1] = adc;
    if (poll_total < POLL_CEILING) begin
      poll_total++;
    end
    used = (poll_total < WINDOW_DEPTH) ? poll_total : WINDOW_DEPTH;
    for (int k = 0; k < used; k++) begin
      total += window_hist[WINDOW_DEPTH-1-k];
    end
    return tenths_for_count(total / used);
  endfunction

  task automatic queue_reading(input logic [ADC_W-1:0] adc, input bit typed = 1'b0,
                               input int temp = 0, input range_status_t status = RANGE_OK);
    adc_row_t row;
    row.adc         = adc;
    row.typed       = typed;
    row.want.temp   = TEMP_W'(temp);
    row.want.status = status;
    adc_rows.push_back(row);
  endtask

  // Source side: present rows in order, hold a beat until it is taken,
  // and insert random idle cycles only between beats.
  always @(posedge clk) begin
    temp_reading_t predicted;
    if (rst) begin
      sample_ch.valid <= 1'b0;
    end else begin
      if (sample_ch.valid && sample_ch.ready) begin
        predicted = absorb_reading(sample_ch.adc_sample);
        // Keep the predictor advancing even where the answer was typed in.
        pending_temps.push_back(adc_rows[fed_beats].typed ? adc_rows[fed_beats].want
                                                          : predicted);
        fed_beats++;
      end
      if (!sample_ch.valid || sample_ch.ready) begin
        if (fed_beats < adc_rows.size() &&
            (calm_window || $urandom_range(0, 99) >= IDLE_PCT)) begin
          sample_ch.valid      <= 1'b1;
          sample_ch.adc_sample <= adc_rows[fed_beats].adc;
        end else begin
          sample_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Sink side: stall at random and check every result beat against the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (pending_temps.size() == 0) begin
          $error("result beat with no prediction waiting: temp_tenths_c %0d range_status %0d",
                 result_ch.temp_tenths_c, result_ch.range_status);
          error_count++;
        end else begin
          head_temp = pending_temps.pop_front();
          if (result_ch.temp_tenths_c !== head_temp.temp) begin
            $error("temp_tenths_c mismatch: expected %0d, actual %0d",
                   head_temp.temp, result_ch.temp_tenths_c);
            error_count++;
          end
          if (result_ch.range_status !== head_temp.status) begin
            $error("range_status mismatch: expected %0d, actual %0d",
                   head_temp.status, result_ch.range_status);
            error_count++;
          end
        end
      end
      result_ch.ready <= calm_window || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  initial begin
    int          run_len;
    int          level;
    int          jitter;
    int          value;
    int unsigned pick;

    for (int k = 0; k < WINDOW_DEPTH; k++) begin
      window_hist[k] = '0;
    end
    poll_total  = 0;
    fed_beats   = 0;
    error_count = 0;

    // Directed rows, starting from an empty window.
    queue_reading(10'd0, 1'b1, -270, RANGE_COLD);   // first poll averages one reading
    repeat (7) queue_reading(10'd1023);             // window fills, average climbs
    queue_reading(10'd1023, 1'b1, 1000, RANGE_HOT); // full window past the table end
    repeat (7) queue_reading(10'd65);
    queue_reading(10'd65, 1'b1, -270, RANGE_OK);    // exactly on the table base
    queue_reading(10'd64, 1'b1, -270, RANGE_COLD);  // average drops one below base
    queue_reading(10'd949);
    queue_reading(10'd512);
    queue_reading(10'd1022);

    // Random rows: mostly steady runs that pin the average at a chosen level,
    // the rest single readings and short bursts of noise.
    while (adc_rows.size() < RANDOM_TOTAL) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        run_len = $urandom_range(WINDOW_DEPTH, WINDOW_DEPTH + 6);
        case ($urandom_range(0, 4))
          0: level = $urandom_range(0, 1023);
          1: level = $urandom_range(55, 75);     // around the cold edge
          2: level = $urandom_range(930, 965);   // last steps and the hot edge
          3: level = $urandom_range(966, 1023);
          default: level = $urandom_range(65, 949);
        endcase
        for (int i = 0; i < run_len; i++) begin
          jitter = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) - 2 : 0;
          value  = level + jitter;
          if (value < 0) value = 0;
          if (value > 1023) value = 1023;
          queue_reading(ADC_W'(value));
        end
      end else begin
        run_len = $urandom_range(1, 3);
        for (int i = 0; i < run_len; i++) begin
          queue_reading(ADC_W'($urandom_range(0, 1023)));
        end
      end
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Wait for every row to be taken and every prediction to be answered,
    // then drain long enough to catch a stray extra beat.
    while (fed_beats < adc_rows.size() || pending_temps.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Cap the run well beyond the slowest legal pass through all rows.
  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
